// ===== sv/nr_transport_block_size_macros.svh =====
// ----------------------------------------------------------------------------
// NR transport block size: assertion macros
// Shorthand for the clocked, reset-qualified assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef NR_TRANSPORT_BLOCK_SIZE_MACROS_SVH
`define NR_TRANSPORT_BLOCK_SIZE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define NRTBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define NRTBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nrtbs_pkg.sv =====
// ----------------------------------------------------------------------------
// NR transport block size: package
// Constants, the TBS table and the structures passed between stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrtbs_pkg;

  localparam int TBS_TABLE_ENTRIES = 93;
  localparam int MAX_BLOCKS        = 275;
  localparam int MAX_LAYERS        = 4;
  localparam int RE_CAP            = 156;
  localparam int SUBCARRIERS       = 12;
  localparam int SMALL_LIMIT       = 3824;
  localparam int CB_LOW_RATE       = 3816;
  localparam int CB_HIGH_RATE      = 8424;
  localparam int CRC_BITS          = 24;
  localparam int LARGE_FLOOR       = 3840;
  localparam int LOW_RATE_MAX      = 512;

  localparam int NINFO_W  = 21;   // Ninfo and the TBS itself
  localparam int SMALL_W  = 12;   // quantised Ninfo on the table path
  localparam int TOT_W    = 22;   // quantised Ninfo plus CRC, large path
  localparam int C_W      = 9;    // code block count
  localparam int DIV_W    = 12;   // eight times the code block count
  localparam int QUO_W    = 11;   // bytes per code block
  localparam int REM_W    = 23;   // running remainder in the divider
  localparam int DIV_STAGES = 3;
  localparam int DIV_STEP   = 4;

  // Exact reciprocals for the ceiling divisions by the code block limits.
  localparam int RECIP_W    = 23;
  localparam int LOW_SHIFT  = TOT_W + 12;
  localparam int HIGH_SHIFT = TOT_W + 14;
  localparam longint LOW_RECIP =
    ((longint'(1) << LOW_SHIFT) + CB_LOW_RATE - 1) / CB_LOW_RATE;
  localparam longint HIGH_RECIP =
    ((longint'(1) << HIGH_SHIFT) + CB_HIGH_RATE - 1) / CB_HIGH_RATE;

  localparam logic [SMALL_W-1:0] TBS_TABLE [TBS_TABLE_ENTRIES] = '{
    12'd24, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd72, 12'd80, 12'd88,
    12'd96, 12'd104, 12'd112, 12'd120, 12'd128, 12'd136, 12'd144, 12'd152,
    12'd160, 12'd168, 12'd176, 12'd184, 12'd192, 12'd208, 12'd224, 12'd240,
    12'd256, 12'd272, 12'd288, 12'd304, 12'd320, 12'd336, 12'd352, 12'd368,
    12'd384, 12'd408, 12'd432, 12'd456, 12'd480, 12'd504, 12'd528, 12'd552,
    12'd576, 12'd608, 12'd640, 12'd672, 12'd704, 12'd736, 12'd768, 12'd808,
    12'd848, 12'd888, 12'd928, 12'd984, 12'd1032, 12'd1064, 12'd1128,
    12'd1160, 12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352,
    12'd1416, 12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800,
    12'd1864, 12'd1928, 12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280,
    12'd2408, 12'd2472, 12'd2536, 12'd2600, 12'd2664, 12'd2728, 12'd2792,
    12'd2856, 12'd2976, 12'd3104, 12'd3240, 12'd3368, 12'd3496, 12'd3624,
    12'd3752, 12'd3824
  };

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]  num_layers;
    logic [10:0] code_rate;
    logic [1:0]  modulation;
    logic [3:0]  symbols_per_slot;
    logic [8:0]  num_blocks;
  } alloc_t;

  typedef struct packed {
    logic [NINFO_W-1:0] ninfo;
    logic               low_rate;
  } ninfo_t;

  typedef struct packed {
    logic               is_large;
    logic [NINFO_W-1:0] small_tbs;
    logic [TOT_W-1:0]   total;
    logic [C_W-1:0]     cb_count;
  } seg_t;

  typedef struct packed {
    logic               is_large;
    logic [NINFO_W-1:0] small_tbs;
    logic [DIV_W-1:0]   divisor;
    logic [QUO_W-1:0]   quot;
  } div_res_t;

endpackage

// ===== sv/nrtbs_ninfo.sv =====
// ----------------------------------------------------------------------------
// NR transport block size: Ninfo pipeline
// Three stages: saturation and RE count, two partial products, final product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrtbs_ninfo
  import nrtbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  alloc_t alloc,
  output logic   out_valid,
  output ninfo_t out
);

  logic [7:0]  re_sat;
  logic [8:0]  blocks_sat;
  logic [2:0]  layers_sat;
  logic [3:0]  qm;
  logic [7:0]  re_raw;

  logic        v1, v2;
  logic [7:0]  re;
  logic [8:0]  blocks;
  logic [5:0]  qml;
  logic [10:0] rate;
  logic        low1, low2;
  logic [15:0] p_re, p_rate;

  always_comb begin
    blocks_sat = (alloc.num_blocks > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : alloc.num_blocks;
    layers_sat = (alloc.num_layers > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : alloc.num_layers;
    re_raw     = 8'(alloc.symbols_per_slot) * 8'(SUBCARRIERS) - 8'd1;
    if (alloc.symbols_per_slot == 4'd0) begin
      re_sat = 8'd0;
    end else if (re_raw > 8'(RE_CAP)) begin
      re_sat = 8'(RE_CAP);
    end else begin
      re_sat = re_raw;
    end
    qm = (4'(alloc.modulation) + 4'd1) << 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re        <= re_sat;
      blocks    <= blocks_sat;
      qml       <= 6'(qm) * 6'(layers_sat);
      rate      <= alloc.code_rate;
      low1      <= (alloc.code_rate <= 11'(LOW_RATE_MAX));
      p_re      <= 16'(re) * 16'(blocks);
      p_rate    <= 16'(qml) * 16'(rate);
      low2      <= low1;
      out.ninfo <= NINFO_W'((32'(p_re) * 32'(p_rate)) >> 11);
      out.low_rate <= low2;
    end
  end

endmodule

// ===== sv/nrtbs_quant.sv =====
// ----------------------------------------------------------------------------
// NR transport block size: quantisation and segmentation
// Two stages: quantise Ninfo, then table lookup or code block count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrtbs_quant
  import nrtbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  ninfo_t in,
  output logic   out_valid,
  output seg_t   out
);

  logic               v4;
  logic               large4, zero4, low4;
  logic [SMALL_W-1:0] q_small;
  logic [TOT_W-1:0]   q_large;

  logic [3:0]         lg_s, n_s;
  logic [SMALL_W-1:0] qs;
  logic [NINFO_W-1:0] x;
  logic [4:0]         lg_l, n_l;
  logic [TOT_W-1:0]   rnd, ql;

  logic [NINFO_W-1:0]     lookup;
  logic [TOT_W-1:0]       q_clamped, total, y_low, y_high;
  logic [TOT_W+RECIP_W-1:0] pr_low, pr_high;
  logic [C_W-1:0]         cb;

  // Stage four: quantisation of both paths.
  always_comb begin
    lg_s = 4'd0;
    for (int i = 0; i < SMALL_W; i++) begin
      if (in.ninfo[i]) lg_s = 4'(i);
    end
    n_s = (lg_s >= 4'd9) ? lg_s - 4'd6 : 4'd3;
    qs  = (in.ninfo[SMALL_W-1:0] >> n_s) << n_s;
    if (qs < SMALL_W'(CRC_BITS)) qs = SMALL_W'(CRC_BITS);

    x    = in.ninfo - NINFO_W'(CRC_BITS);
    lg_l = 5'd0;
    for (int i = 0; i < NINFO_W; i++) begin
      if (x[i]) lg_l = 5'(i);
    end
    n_l = lg_l - 5'd5;
    rnd = TOT_W'(x) + (TOT_W'(1) << (n_l - 5'd1));
    ql  = rnd & ~((TOT_W'(1) << n_l) - TOT_W'(1));
  end

  // Stage five: table search on one path, code block count on the other.
  always_comb begin
    lookup = '0;
    for (int j = 0; j < TBS_TABLE_ENTRIES; j++) begin
      if (TBS_TABLE[j] >= q_small && (j == 0 || TBS_TABLE[(j == 0) ? 0 : j - 1] < q_small))
        lookup = lookup | NINFO_W'(TBS_TABLE[j]);
    end
    if (zero4) lookup = '0;

    q_clamped = (q_large < TOT_W'(LARGE_FLOOR)) ? TOT_W'(LARGE_FLOOR) : q_large;
    total     = q_clamped + TOT_W'(CRC_BITS);
    y_low     = total + TOT_W'(CB_LOW_RATE - 1);
    y_high    = total + TOT_W'(CB_HIGH_RATE - 1);
    pr_low    = (TOT_W+RECIP_W)'(y_low) * (TOT_W+RECIP_W)'(LOW_RECIP);
    pr_high   = (TOT_W+RECIP_W)'(y_high) * (TOT_W+RECIP_W)'(HIGH_RECIP);
    priority if (low4) begin
      cb = C_W'(pr_low >> LOW_SHIFT);
    end else if (q_clamped > TOT_W'(CB_HIGH_RATE)) begin
      cb = C_W'(pr_high >> HIGH_SHIFT);
    end else begin
      cb = C_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= in_valid;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      large4        <= (in.ninfo > NINFO_W'(SMALL_LIMIT));
      zero4         <= (in.ninfo == '0);
      low4          <= in.low_rate;
      q_small       <= qs;
      q_large       <= ql;
      out.is_large  <= large4;
      out.small_tbs <= lookup;
      out.total     <= total;
      out.cb_count  <= cb;
    end
  end

endmodule

// ===== sv/nrtbs_div.sv =====
// ----------------------------------------------------------------------------
// NR transport block size: pipelined ceiling divider
// Bytes per code block, ceil(total / (8 * C)), four quotient bits a stage, three in the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrtbs_div
  import nrtbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  seg_t     in,
  output logic     out_valid,
  output div_res_t out
);

  logic [DIV_STAGES-1:0] v;
  logic [REM_W-1:0]      rem_q [DIV_STAGES];
  logic [QUO_W-1:0]      quo_q [DIV_STAGES];
  logic [DIV_W-1:0]      div_q [DIV_STAGES];
  logic                  large_q [DIV_STAGES];
  logic [NINFO_W-1:0]    small_q [DIV_STAGES];

  logic [DIV_W-1:0]      d0;

  assign d0 = {in.cb_count, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DIV_STAGES-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_W-1:0]   rem_in, rem_nx, trial;
    logic [QUO_W-1:0]   quo_in, quo_nx;
    logic [DIV_W-1:0]   div_in;
    logic               large_in;
    logic [NINFO_W-1:0] small_in;

    if (s == 0) begin : g_first
      assign rem_in   = REM_W'(in.total) + REM_W'(d0) - REM_W'(1);
      assign quo_in   = '0;
      assign div_in   = d0;
      assign large_in = in.is_large;
      assign small_in = in.small_tbs;
    end else begin : g_rest
      assign rem_in   = rem_q[s-1];
      assign quo_in   = quo_q[s-1];
      assign div_in   = div_q[s-1];
      assign large_in = large_q[s-1];
      assign small_in = small_q[s-1];
    end

    always_comb begin
      rem_nx = rem_in;
      quo_nx = quo_in;
      trial  = '0;
      for (int k = 0; k < DIV_STEP; k++) begin
        if (QUO_W - 1 - (s * DIV_STEP + k) >= 0) begin
          trial = REM_W'(div_in) << (QUO_W - 1 - (s * DIV_STEP + k));
          if (rem_nx >= trial) begin
            rem_nx = rem_nx - trial;
            quo_nx[QUO_W - 1 - (s * DIV_STEP + k)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]   <= rem_nx;
        quo_q[s]   <= quo_nx;
        div_q[s]   <= div_in;
        large_q[s] <= large_in;
        small_q[s] <= small_in;
      end
    end
  end

  assign out_valid     = v[DIV_STAGES-1];
  assign out.is_large  = large_q[DIV_STAGES-1];
  assign out.small_tbs = small_q[DIV_STAGES-1];
  assign out.divisor   = div_q[DIV_STAGES-1];
  assign out.quot      = quo_q[DIV_STAGES-1];

endmodule

// ===== sv/nr_transport_block_size.sv =====
// ----------------------------------------------------------------------------
// NR transport block size: top level
// One allocation item in, one transport block size in bits out.
// ----------------------------------------------------------------------------
// Each item carries a codeword's allocation (resource blocks, usable symbols,
// modulation, code rate in 1/2048 units and layers) and yields the 5G NR
// transport block size in bits. The block is a nine-stage pipeline: three
// stages form Ninfo, two quantise it and either look up the small-size table
// or count code blocks, three divide out the bytes per code block, and the
// last multiplies back into the output register. An item is accepted in
// every cycle while the output is free or being taken, so the sustained rate
// is one item per clock. Each result is held in the output register on the
// master side until it is taken. A stall on the master side holds the
// whole pipeline, and s_tready drops in the same cycle.
`timescale 1ns / 1ps
`include "nr_transport_block_size_macros.svh"

module nr_transport_block_size
  import nrtbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // num_blocks[8:0], symbols_per_slot[12:9], modulation[14:13],
  // code_rate[25:15], num_layers[28:26], zeros above
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tbs_bits[20:0], zeros above
  output logic [23:0] m_tdata
);

  logic     en;
  alloc_t   alloc;
  logic     ninfo_valid, seg_valid, div_valid;
  ninfo_t   ninfo;
  seg_t     seg;
  div_res_t div_res;
  logic [NINFO_W-1:0] tbs;

  // The whole pipeline moves when the output register is empty or drained.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign alloc    = alloc_t'(s_tdata[28:0]);

  nrtbs_ninfo u_ninfo (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .alloc     (alloc),
    .out_valid (ninfo_valid),
    .out       (ninfo)
  );

  nrtbs_quant u_quant (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ninfo_valid),
    .in        (ninfo),
    .out_valid (seg_valid),
    .out       (seg)
  );

  nrtbs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (seg_valid),
    .in        (seg),
    .out_valid (div_valid),
    .out       (div_res)
  );

  // Large sizes are whole bytes per code block across all blocks, less CRC.
  always_comb begin
    if (div_res.is_large) begin
      tbs = NINFO_W'(23'(div_res.divisor) * 23'(div_res.quot) - 23'(CRC_BITS));
    end else begin
      tbs = div_res.small_tbs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {3'b000, tbs};
    end
  end

  `NRTBS_ASSERT_IMP(a_whole_bytes, m_tvalid, m_tdata[2:0] == 3'd0, "TBS not a whole number of bytes")
  `NRTBS_ASSERT_IMP(a_min_size, m_tvalid && (m_tdata != 24'd0), m_tdata >= 24'(CRC_BITS), "TBS below minimum")
  `NRTBS_ASSERT_IMP(a_stall_holds_input, m_tvalid && !m_tready, !s_tready, "input taken while stalled")
  `NRTBS_ASSERT_NXT(a_result_lands, div_valid && en, m_tvalid, "result lost at output register")

endmodule

// ===== dv/nr_transport_block_size_test.sv =====
// ----------------------------------------------------------------------------
// NR transport block size: testbench
// Drives allocation items with random gaps and back-pressure, predicts each
// transport block size independently and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the expected sizes and does the comparison.
class tbs_scoreboard;
  logic [20:0] expected_sizes[$];
  int          errors;
  int          checked;

  static const int table_sizes[93] = '{
    24, 32, 40, 48, 56, 64, 72, 80, 88, 96, 104, 112, 120, 128, 136, 144,
    152, 160, 168, 176, 184, 192, 208, 224, 240, 256, 272, 288, 304, 320,
    336, 352, 368, 384, 408, 432, 456, 480, 504, 528, 552, 576, 608, 640,
    672, 704, 736, 768, 808, 848, 888, 928, 984, 1032, 1064, 1128, 1160,
    1192, 1224, 1256, 1288, 1320, 1352, 1416, 1480, 1544, 1608, 1672, 1736,
    1800, 1864, 1928, 2024, 2088, 2152, 2216, 2280, 2408, 2472, 2536, 2600,
    2664, 2728, 2792, 2856, 2976, 3104, 3240, 3368, 3496, 3624, 3752, 3824};

  static function int msb_index(longint v);
    int p;
    p = 0;
    while (v > 1) begin
      v = v >> 1;
      p++;
    end
    return p;
  endfunction

  static function longint size_for(nrtbs_pkg::alloc_t a);
    longint blocks, layers, re, ninfo, q, x, total, c;
    int n, j;
    blocks = (a.num_blocks > 275) ? 275 : a.num_blocks;
    layers = (a.num_layers > 4) ? 4 : a.num_layers;
    re = (a.symbols_per_slot == 0) ? 0 : 12 * a.symbols_per_slot - 1;
    if (re > 156) re = 156;
    ninfo = (re * blocks * ((a.modulation + 1) * 2) * layers * a.code_rate) >> 11;
    if (blocks == 0 || ninfo == 0) return 0;
    if (ninfo <= 3824) begin
      n = msb_index(ninfo);
      n = (n >= 9) ? n - 6 : 3;
      q = (ninfo >> n) << n;
      if (q < 24) q = 24;
      for (j = 0; j < 92; j++) if (table_sizes[j] >= q) break;
      return table_sizes[j];
    end
    x = ninfo - 24;
    n = msb_index(x) - 5;
    q = ((x + (longint'(1) << (n - 1))) >> n) << n;
    if (q < 3840) q = 3840;
    total = q + 24;
    if (a.code_rate <= 512) c = (total + 3815) / 3816;
    else if (q > 8424) c = (total + 8423) / 8424;
    else c = 1;
    return 8 * c * ((total + 8 * c - 1) / (8 * c)) - 24;
  endfunction

  function void note_allocation(nrtbs_pkg::alloc_t a);
    expected_sizes = {expected_sizes, 21'(size_for(a))};
  endfunction

  function void check_size(logic [23:0] data);
    logic [20:0] want;
    if (expected_sizes.size() == 0) begin
      $error("tbs_bits: result %0d arrived with nothing expected", data[20:0]);
      errors++;
      return;
    end
    want = expected_sizes.pop_front();
    checked++;
    if (data[20:0] !== want) begin
      $error("tbs_bits: expected %0d, actual %0d", want, data[20:0]);
      errors++;
    end
    if (data[23:21] !== 3'b000) begin
      $error("tdata padding: expected 0, actual %0d", data[23:21]);
      errors++;
    end
  endfunction
endclass

module nr_transport_block_size_test;
  import nrtbs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  tbs_scoreboard scoreboard = new();
  bit            stimulus_done = 1'b0;
  // Set while a stretch of items is sent back to back with an open sink.
  bit            burst_mode = 1'b0;

  always #6 clk = ~clk;

  nr_transport_block_size u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if (burst_mode) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 5);
    return ($urandom_range(2) == 0) ? $urandom_range(3) : 0;
  endfunction

  // Offers one allocation item and holds it until it is taken. The valid
  // line only drops when a gap follows, so back-to-back items keep it high.
  task automatic send_allocation(alloc_t a);
    int gap;
    gap = gap_length();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    scoreboard.note_allocation(a);
    @(negedge clk);
  endtask

  task automatic send_fields(int nb, int sym, int mods, int rate, int lay);
    alloc_t a;
    a.num_blocks = 9'(nb);
    a.symbols_per_slot = 4'(sym);
    a.modulation = 2'(mods);
    a.code_rate = 11'(rate);
    a.num_layers = 3'(lay);
    send_allocation(a);
  endtask

  // Sink side: random back-pressure, results checked at the rising edge.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = gap_length();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) scoreboard.check_size(m_tdata);

  initial begin
    alloc_t a;
    int k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero blocks, zero symbols, zero rate, zero layers, saturation
    // of blocks, layers and symbols, each modulation, small and large paths.
    send_fields(0, 14, 3, 2047, 4);
    send_fields(275, 0, 3, 2047, 4);
    send_fields(275, 14, 3, 0, 4);
    send_fields(275, 14, 3, 2047, 0);
    send_fields(511, 15, 3, 2047, 7);
    send_fields(275, 14, 3, 2047, 4);
    send_fields(1, 1, 0, 1, 1);
    send_fields(1, 1, 0, 2047, 1);
    send_fields(1, 14, 1, 1024, 1);
    send_fields(10, 12, 2, 600, 2);
    send_fields(20, 12, 0, 512, 1);
    send_fields(20, 12, 0, 513, 1);
    send_fields(100, 12, 3, 512, 4);
    send_fields(100, 12, 3, 900, 4);
    send_fields(50, 13, 1, 300, 3);
    send_fields(300, 14, 2, 1500, 5);
    send_fields(4, 12, 1, 700, 2);
    send_fields(3, 12, 2, 1000, 1);
    send_fields(256, 8, 2, 1234, 6);

    // Random: mostly legal allocations; some with sizes aimed at the small
    // table path, a few with every field fully random.
    for (k = 0; k < 1750; k++) begin
      burst_mode = (k % 300) >= 260;
      a = alloc_t'(29'($urandom));
      case ($urandom_range(3))
        0: ;
        1: begin
          a.num_blocks = 9'($urandom_range(8, 1));
          a.num_layers = 3'($urandom_range(4, 1));
          a.symbols_per_slot = 4'($urandom_range(14, 1));
        end
        default: begin
          a.num_blocks = 9'($urandom_range(275, 1));
          a.num_layers = 3'($urandom_range(4, 1));
          a.symbols_per_slot = 4'($urandom_range(14, 1));
          a.code_rate = 11'($urandom_range(2047, 1));
        end
      endcase
      send_allocation(a);
    end
    s_tvalid <= 1'b0;
    burst_mode = 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    while (scoreboard.expected_sizes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Checked %0d transport block sizes over directed and random allocations,",
             scoreboard.checked);
    $display("with gaps and back-pressure on both streams.");
    if (scoreboard.errors == 0) begin
      $display("nr_transport_block_size verification clean");
    end else begin
      $display("nr_transport_block_size verification failed");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #10_000_000;
    $display("nr_transport_block_size verification failed");
    $finish;
  end

endmodule
